@@ hdl/robin_hood_hash_table_core_assert.svh @@
// Assertion macros used by the hash table core.
`ifndef ROBIN_HOOD_HASH_TABLE_CORE_ASSERT_SVH
`define ROBIN_HOOD_HASH_TABLE_CORE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define RHHT_CHECK(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define RHHT_IMPLY(name, trig, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/rhht_pkg.sv @@
package rhht_pkg;

   localparam int SLOTS_DEF     = 256;
   localparam int KEY_BYTES_DEF = 8;

   localparam int KEY_W   = 64;
   localparam int VAL_W   = 64;
   localparam int HASH_W  = 64;
   localparam int LEN_W   = 4;
   localparam int PROBE_W = 8;
   localparam int COUNT_W = 9;

   // FNV-1a 64: prime is 2^40 + 0x1b3
   localparam logic [HASH_W-1:0] FNV_BASIS    = 64'hcbf29ce484222325;
   localparam logic [HASH_W-1:0] FNV_PRIME    = 64'h00000100000001b3;
   localparam int                FNV_SHIFT    = 40;
   localparam logic [8:0]        FNV_PRIME_LO = FNV_PRIME[8:0];

   localparam logic [COUNT_W-1:0] LIMIT_RESET    = 9'd192;
   localparam logic [2:0]         REG_LOAD_LIMIT = 3'd0;

   typedef enum logic [1:0] {
      OP_PUT    = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_UPDATED   = 3'd1,
      ST_FOUND     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_REMOVED   = 3'd4,
      ST_FULL      = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_FIND_RD,
      S_FIND_CHK,
      S_PLACE_RD,
      S_PLACE_CHK,
      S_ERASE_RD,
      S_ERASE_CHK,
      S_ERASE_END,
      S_RESP
   } state_type;

   typedef struct packed {
      logic                used;
      logic [PROBE_W-1:0]  probe;
      logic [LEN_W-1:0]    len;
      logic [KEY_W-1:0]    key;
      logic [VAL_W-1:0]    value;
   } slot_type;

   typedef struct packed {
      logic              start;
      logic [LEN_W-1:0]  len;
      logic [KEY_W-1:0]  key;
   } hash_cmd_type;

   function automatic logic [KEY_W-1:0] key_mask(input logic [LEN_W-1:0] len);
      logic [KEY_W-1:0] m;
      m = '0;
      for (int i = 0; i < KEY_W / 8; i++) begin
         m[8*i +: 8] = (LEN_W'(i) < len) ? 8'hff : 8'h00;
      end
      return m;
   endfunction

   // one FNV-1a byte round; the 64-bit product splits into a shift and a narrow multiply
   function automatic logic [HASH_W-1:0] fnv_round(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
      logic [HASH_W-1:0] x;
      x = h ^ {56'b0, b};
      return (x << FNV_SHIFT) + HASH_W'(x * FNV_PRIME_LO);
   endfunction

endpackage

@@ hdl/robin_hood_hash_table_core.sv @@
// Sequence: the key is hashed byte by byte, then the lookup walk reads and checks each probed slot;
//   a put that misses walks again from the home slot to insert, and a remove that hits shifts the
//   cluster tail back and ends with a step that empties the last moved slot; then the result transfer.
// Throughput: one item at a time; the next transfer is taken after the result is taken.
// Reset: synchronous; after reset the slot memory is swept clear, one slot per cycle, with
//   req_tready low. Configuration writes are taken during the sweep.
module robin_hood_hash_table_core #(
   parameter int SLOTS     = rhht_pkg::SLOTS_DEF,     // power of two
   parameter int KEY_BYTES = rhht_pkg::KEY_BYTES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   // request transfer
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [135:0]  req_tdata,   // key_len[3:0], key_bytes[67:4], value_in[131:68], zero
   input  logic [1:0]    req_tuser,   // opcode[1:0]
   // result transfer
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [143:0]  rsp_tdata,   // value_out[63:0], hash_out[127:64], entry_total[136:128]
   output logic [2:0]    rsp_tuser,   // status[2:0]
   // register port
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);
   import rhht_pkg::*;

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int DIST_W = IDX_W + 1;
   localparam int SLOT_W = $bits(slot_type);

   // ---------------------------------------------------------------- registers
   state_type             state_ff, state_in;
   logic [1:0]            op_ff, op_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [VAL_W-1:0]      val_ff, val_in;
   logic [HASH_W-1:0]     hash_ff, hash_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;      // walk index, also the clear sweep address
   logic [DIST_W-1:0]     dist_ff, dist_in;    // probe distance / walk step count
   slot_type              carry_ff, carry_in;  // entry being carried by the insert walk
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [COUNT_W-1:0]    limit_ff, limit_in;
   status_type            status_ff, status_in;
   logic [VAL_W-1:0]      vout_ff, vout_in;

   // ---------------------------------------------------------------- slot memory
   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr, ram_raddr;
   slot_type              ram_wdata;
   logic [SLOT_W-1:0]     ram_rdata;
   slot_type              rd;

   assign rd = slot_type'(ram_rdata);

   rhht_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // ---------------------------------------------------------------- hash unit
   hash_cmd_type          hcmd;
   logic                  hash_done;
   logic [HASH_W-1:0]     hash_val;

   rhht_hash u_hash (
      .clock (clock),
      .reset (reset),
      .cmd   (hcmd),
      .done  (hash_done),
      .hash  (hash_val)
   );

   // ---------------------------------------------------------------- request decode
   logic                  req_xfer;
   logic [LEN_W-1:0]      req_len;
   logic [KEY_W-1:0]      req_key;

   assign req_xfer = req_tvalid && req_tready;
   // overlong keys are cut to KEY_BYTES; bytes past the length never matter
   assign req_len  = (req_tdata[3:0] > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : req_tdata[3:0];
   assign req_key  = req_tdata[67:4] & key_mask(req_len);

   // ---------------------------------------------------------------- slot checks
   logic                  walk_over;   // SLOTS slots visited
   logic                  find_miss;
   logic                  find_hit;
   logic                  table_full;
   logic                  erase_stop;
   logic [IDX_W-1:0]      idx_prev;

   assign walk_over  = dist_ff[IDX_W];
   assign find_miss  = walk_over || !rd.used || (32'(rd.probe) < 32'(dist_ff));
   assign find_hit   = !find_miss && (rd.len == len_ff) && (rd.key == key_ff);
   assign table_full = (limit_ff <= count_ff) || (32'(count_ff) >= SLOTS);
   assign erase_stop = walk_over || !rd.used || (rd.probe == '0);
   assign idx_prev   = idx_ff - 1'b1;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:     if (idx_ff == IDX_W'(SLOTS - 1)) state_in = S_IDLE;
         S_IDLE:      if (req_xfer) state_in = S_HASH;
         S_HASH:      if (hash_done) state_in = S_FIND_RD;
         S_FIND_RD:   state_in = S_FIND_CHK;
         S_FIND_CHK: begin
            if (find_hit) begin
               state_in = (op_ff == OP_REMOVE) ? S_ERASE_RD : S_RESP;
            end else if (find_miss) begin
               state_in = (op_ff == OP_PUT && !table_full) ? S_PLACE_RD : S_RESP;
            end else begin
               state_in = S_FIND_RD;
            end
         end
         S_PLACE_RD:  state_in = S_PLACE_CHK;
         S_PLACE_CHK: state_in = (walk_over || !rd.used) ? S_RESP : S_PLACE_RD;
         S_ERASE_RD:  state_in = S_ERASE_CHK;
         S_ERASE_CHK: state_in = erase_stop ? S_ERASE_END : S_ERASE_RD;
         S_ERASE_END: state_in = S_RESP;
         S_RESP:      if (rsp_tready) state_in = S_IDLE;
         default:     state_in = S_CLEAR;
      endcase
   end

   // ---------------------------------------------------------------- datapath and outputs
   always_comb begin
      op_in     = op_ff;
      len_in    = len_ff;
      key_in    = key_ff;
      val_in    = val_ff;
      hash_in   = hash_ff;
      idx_in    = idx_ff;
      dist_in   = dist_ff;
      carry_in  = carry_ff;
      count_in  = count_ff;
      status_in = status_ff;
      vout_in   = vout_ff;
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = '0;
      ram_raddr = idx_ff;
      hcmd      = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            idx_in = idx_ff + 1'b1;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_xfer) begin
               op_in      = req_tuser;
               len_in     = req_len;
               key_in     = req_key;
               val_in     = req_tdata[131:68];
               hcmd.start = 1'b1;
               hcmd.len   = req_len;
               hcmd.key   = req_key;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               hash_in = hash_val;
               idx_in  = hash_val[IDX_W-1:0];
               dist_in = '0;
            end
         end
         S_FIND_RD: begin
         end
         S_FIND_CHK: begin
            status_in = ST_NOT_FOUND;
            vout_in   = '0;
            if (find_hit) begin
               unique case (op_ff)
                  OP_PUT: begin
                     ram_we          = 1'b1;
                     ram_wdata       = rd;
                     ram_wdata.value = val_ff;
                     vout_in         = rd.value;
                     status_in       = ST_UPDATED;
                  end
                  OP_LOOKUP: begin
                     vout_in   = rd.value;
                     status_in = ST_FOUND;
                  end
                  OP_REMOVE: begin
                     // empty the hit slot, then shift the cluster tail back
                     ram_we  = 1'b1;
                     idx_in  = idx_ff + 1'b1;
                     dist_in = '0;
                  end
                  default: begin
                  end
               endcase
            end else if (find_miss) begin
               if (op_ff == OP_PUT) begin
                  if (table_full) begin
                     status_in = ST_FULL;
                  end else begin
                     idx_in         = hash_ff[IDX_W-1:0];
                     dist_in        = '0;
                     carry_in.used  = 1'b1;
                     carry_in.probe = '0;
                     carry_in.len   = len_ff;
                     carry_in.key   = key_ff;
                     carry_in.value = val_ff;
                  end
               end
            end else begin
               idx_in  = idx_ff + 1'b1;
               dist_in = dist_ff + 1'b1;
            end
         end
         S_PLACE_RD: begin
         end
         S_PLACE_CHK: begin
            if (walk_over) begin
               status_in = ST_INSERTED;
               count_in  = count_ff + 1'b1;
            end else if (!rd.used) begin
               ram_we    = 1'b1;
               ram_wdata = carry_ff;
               status_in = ST_INSERTED;
               count_in  = count_ff + 1'b1;
            end else begin
               // richer resident gives its slot up and is carried on
               if (carry_ff.probe > rd.probe) begin
                  ram_we         = 1'b1;
                  ram_wdata      = carry_ff;
                  carry_in       = rd;
                  carry_in.probe = rd.probe + 1'b1;
               end else begin
                  carry_in.probe = carry_ff.probe + 1'b1;
               end
               idx_in  = idx_ff + 1'b1;
               dist_in = dist_ff + 1'b1;
            end
         end
         S_ERASE_RD: begin
         end
         S_ERASE_CHK: begin
            if (!erase_stop) begin
               // slot idx moves back one; it is emptied lazily, by the next
               // move into it or at the end of the walk
               ram_we          = 1'b1;
               ram_waddr       = idx_prev;
               ram_wdata       = rd;
               ram_wdata.probe = rd.probe - 1'b1;
               idx_in          = idx_ff + 1'b1;
               dist_in         = dist_ff + 1'b1;
            end
         end
         S_ERASE_END: begin
            if (dist_ff != '0) begin
               ram_we    = 1'b1;
               ram_waddr = idx_prev;
            end
            if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end
            status_in = ST_REMOVED;
            vout_in   = '0;
         end
         S_RESP: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------- register port
   logic csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == REG_LOAD_LIMIT) ? {23'b0, limit_ff} : 32'b0;

   always_comb begin
      limit_in = limit_ff;
      if (csr_wr && csr_paddr == REG_LOAD_LIMIT) begin
         limit_in = csr_pwdata[COUNT_W-1:0];
      end
   end

   // ---------------------------------------------------------------- result
   assign rsp_tuser = status_ff;
   assign rsp_tdata = {7'b0, count_ff, hash_ff, vout_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff   <= '0;
         count_ff <= '0;
         limit_ff <= LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
         limit_ff <= limit_in;
      end
      op_ff     <= op_in;
      len_ff    <= len_in;
      key_ff    <= key_in;
      val_ff    <= val_in;
      hash_ff   <= hash_in;
      dist_ff   <= dist_in;
      carry_ff  <= carry_in;
      status_ff <= status_in;
      vout_ff   <= vout_in;
   end

   // ---------------------------------------------------------------- checks
   logic store_idle;   // no walk in progress

   assign store_idle = (state_ff == S_IDLE) || (state_ff == S_RESP);

`include "robin_hood_hash_table_core_assert.svh"

   `RHHT_CHECK(a_one_item, !(req_tready && rsp_tvalid), "request taken while result pending")
   `RHHT_CHECK(a_count_bound, 32'(count_ff) <= SLOTS, "entry count above slot count")
   `RHHT_CHECK(a_quiet_store, !(ram_we && store_idle), "slot write while idle")
   `RHHT_IMPLY(a_resp_idle, rsp_tvalid && rsp_tready, req_tready, "not ready after result transfer")

endmodule

@@ hdl/rhht_ram.sv @@
module rhht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ hdl/rhht_hash.sv @@
module rhht_hash (
   input  logic                  clock,
   input  logic                  reset,
   input  rhht_pkg::hash_cmd_type cmd,
   output logic                  done,
   output logic [63:0]           hash
);
   import rhht_pkg::*;

   logic                 active_ff, active_in;
   logic [LEN_W-1:0]     cnt_ff, cnt_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [HASH_W-1:0]    h_ff, h_in;

   assign done = active_ff && (cnt_ff == '0);
   assign hash = h_ff;

   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      key_in    = key_ff;
      h_in      = h_ff;
      if (cmd.start) begin
         active_in = 1'b1;
         cnt_in    = cmd.len;
         key_in    = cmd.key;
         h_in      = FNV_BASIS;
      end else if (active_ff) begin
         if (cnt_ff == '0) begin
            active_in = 1'b0;
         end else begin
            h_in   = fnv_round(h_ff, key_ff[7:0]);
            key_in = key_ff >> 8;
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
      end
      key_ff <= key_in;
      h_ff   <= h_in;
   end

endmodule
